@@ rtl/hbtr_pkg.sv @@
// ----------------------------------------------------------------------------
// hbtr_pkg
// Shared types and constants for the bucketed hash table.
// ----------------------------------------------------------------------------
package hbtr_pkg;

  localparam int DEF_WAYS        = 4;
  localparam int DEF_BUCKET_BITS = 12;
  localparam int BCNT_W          = 13;
  localparam int TAG_W           = 16;
  localparam int WAY_W           = 80;
  localparam int IN_W            = 136;
  localparam int OUT_W           = 64;
  localparam int ADDR_W          = 3;

  typedef enum logic [1:0] {
    CMD_SAVE  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [ADDR_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [ADDR_W-1:0] REG_BCOUNT = 3'd4;

  // one way: tag, depth, value, eval, move, age_type from bit 0 up
  typedef struct packed {
    logic [7:0]  age_type;
    logic [15:0] move;
    logic [15:0] eval;
    logic [15:0] value;
    logic [7:0]  depth;
    logic [15:0] tag;
  } way_t;

  // classified command between front and back
  typedef struct packed {
    cmd_t        cmd;
    logic        enabled;
    logic [15:0] tag;
    logic [7:0]  depth;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [1:0]  btype;
    logic [5:0]  age;
  } op_t;

  typedef struct packed {
    logic        hit;
    logic        stored;
    logic [7:0]  depth;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [1:0]  btype;
  } res_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_OUT
  } bst_t;

endpackage

@@ rtl/hbtr_front.sv @@
// ----------------------------------------------------------------------------
// hbtr_front
// Accepts items, computes the bucket index over two stages (two 32x14
// products, then sum), and pushes classified ops into a two-entry queue.
// ----------------------------------------------------------------------------
module hbtr_front #(
  parameter int BUCKET_BITS = hbtr_pkg::DEF_BUCKET_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hbtr_pkg::IN_W-1:0]   in_data,
  input  logic                        enabled,
  input  logic [hbtr_pkg::BCNT_W-1:0] bcount,
  output logic                        q_valid,
  input  logic                        q_ready,
  output hbtr_pkg::op_t               q_op,
  output logic [BUCKET_BITS-1:0]      q_bucket
);
  import hbtr_pkg::*;

  localparam int NB   = 1 << BUCKET_BITS;
  localparam int NCAP = (NB < 8192) ? NB : 8192;

  logic        s1_valid;
  op_t         s1_op;
  logic [44:0] s1_hi;
  logic [44:0] s1_lo;
  logic [BCNT_W:0] neff;
  logic [63:0] h;
  logic [45:0] sum;
  logic [BUCKET_BITS-1:0] s1_bkt;

  op_t         qa_op, qb_op;
  logic [BUCKET_BITS-1:0] qa_b, qb_b;
  logic [1:0]  qcnt;
  logic        push, pop;

  assign h = in_data[65:2];

  always_comb begin
    neff = {1'b0, bcount};
    if (bcount == '0) neff = 14'd1;
    if (32'(bcount) > NCAP) neff = 14'(NCAP);
  end

  // stage 1 stalls only if queue full and it holds an item
  assign in_ready = !s1_valid || push;
  assign push     = s1_valid && (qcnt != 2'd2 || pop);
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_hi <= 45'(h[63:32] * neff[BCNT_W:0]);
      s1_lo <= 45'(h[31:0] * neff[BCNT_W:0]);
      s1_op.cmd     <= cmd_t'(in_data[1:0]);
      s1_op.enabled <= enabled;
      s1_op.tag     <= in_data[17:2];
      s1_op.depth   <= in_data[73:66];
      s1_op.value   <= in_data[89:74];
      s1_op.eval    <= in_data[105:90];
      s1_op.move    <= in_data[121:106];
      s1_op.btype   <= in_data[123:122];
      s1_op.age     <= in_data[129:124];
    end
  end

  assign sum    = {1'b0, s1_hi} + {33'd0, s1_lo[44:32]};
  assign s1_bkt = BUCKET_BITS'(sum[45:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else begin
      qcnt <= qcnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      qa_op <= qb_op;
      qa_b  <= qb_b;
    end
    if (push) begin
      if ((qcnt == 2'd0) || (qcnt == 2'd1 && pop)) begin
        qa_op <= s1_op;
        qa_b  <= s1_bkt;
      end else begin
        qb_op <= s1_op;
        qb_b  <= s1_bkt;
      end
    end
  end

  assign q_valid  = qcnt != 2'd0;
  assign q_op     = qa_op;
  assign q_bucket = qa_b;
endmodule

@@ rtl/hbtr_back.sv @@
// ----------------------------------------------------------------------------
// hbtr_back
// Bucket memory with read, way choice and write-back; clear sweeps buckets.
// ----------------------------------------------------------------------------
module hbtr_back #(
  parameter int WAYS        = hbtr_pkg::DEF_WAYS,
  parameter int BUCKET_BITS = hbtr_pkg::DEF_BUCKET_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  hbtr_pkg::op_t                q_op,
  input  logic [BUCKET_BITS-1:0]       q_bucket,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hbtr_pkg::OUT_W-1:0]   out_data
);
  import hbtr_pkg::*;

  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS*WAY_W-1:0] mem [1 << BUCKET_BITS];
  logic [WAYS*WAY_W-1:0] rdata;
  way_t                  ways [WAYS];

  bst_t state, state_next;
  logic [BUCKET_BITS-1:0] wptr;
  op_t  op;
  logic [BUCKET_BITS-1:0] bkt;
  res_t res;
  res_t res_d;
  logic clr_resp;

  logic [WI-1:0] pick, hitw;
  logic          tag_hit;
  logic          we;
  logic [BUCKET_BITS-1:0] waddr;
  logic [WAYS*WAY_W-1:0]  wdata;
  way_t          nw;
  logic          skip;
  logic          wipe_last;

  always_comb begin
    for (int i = 0; i < WAYS; i++) ways[i] = way_t'(rdata[i*WAY_W +: WAY_W]);
  end

  // first tag match for both save and load; else stale-then-shallow choice
  always_comb begin
    logic done;
    logic cc, pc, sh;
    pick = '0; hitw = '0; tag_hit = 1'b0; done = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      cc = ways[i].age_type[7:2] == op.age;
      pc = ways[pick].age_type[7:2] == op.age;
      sh = ways[i].depth < ways[pick].depth;
      if (!done) begin
        if (ways[i].tag == op.tag) begin
          pick = WI'(i); hitw = WI'(i); tag_hit = 1'b1; done = 1'b1;
        end else if ((!cc && pc) || (!cc && !pc && sh) || (cc && pc && sh)) begin
          pick = WI'(i);
        end
      end
    end
  end

  assign skip = op.depth == 8'd0 && ways[pick].depth != 8'd0 &&
                ways[pick].age_type[7:2] == op.age;
  assign nw = '{age_type: {op.age, op.btype}, move: op.move, eval: op.eval,
                value: op.value, depth: op.depth, tag: op.tag};

  always_comb begin
    wdata = rdata;
    for (int i = 0; i < WAYS; i++) begin
      if (WI'(i) == pick) wdata[i*WAY_W +: WAY_W] = nw;
    end
  end

  always_comb begin
    res_d = '0;
    if (op.cmd == CMD_SAVE) begin
      res_d.stored = !skip;
    end else if (tag_hit) begin
      res_d.hit   = 1'b1;
      res_d.depth = ways[hitw].depth;
      res_d.value = ways[hitw].value;
      res_d.eval  = ways[hitw].eval;
      res_d.move  = ways[hitw].move;
      res_d.btype = ways[hitw].age_type[1:0];
    end
  end

  assign wipe_last = wptr == '1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE:   if (wipe_last) state_next = clr_resp ? ST_OUT : ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          if (q_op.enabled && q_op.cmd == CMD_CLEAR) state_next = ST_WIPE;
          else if (q_op.enabled && (q_op.cmd == CMD_SAVE || q_op.cmd == CMD_LOAD))
            state_next = ST_READ;
          else state_next = ST_OUT;
        end
      end
      ST_READ:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = state == ST_IDLE;
    out_valid = state == ST_OUT;
    we        = 1'b0;
    waddr     = bkt;
    unique case (state)
      ST_WIPE: begin
        we = 1'b1; waddr = wptr;
      end
      ST_DECIDE: we = op.cmd == CMD_SAVE && !skip;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= (state == ST_WIPE) ? '0 : wdata;
    rdata <= mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_WIPE;
      wptr     <= '0;
      clr_resp <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WIPE) wptr <= wptr + 1'b1;
      if (state == ST_IDLE && q_valid)
        clr_resp <= q_op.enabled && q_op.cmd == CMD_CLEAR;
    end
    if (state == ST_IDLE && q_valid) begin
      op  <= q_op;
      bkt <= q_bucket;
      res <= '0;
    end
    if (state == ST_DECIDE) res <= res_d;
  end

  // clear answers after its sweep
  assign out_data = {4'd0, res.btype, res.move, res.eval, res.value, res.depth,
                     res.stored, res.hit};
endmodule

@@ rtl/hash_bucket_table_replace_unit.sv @@
// ----------------------------------------------------------------------------
// hash_bucket_table_replace_unit
// Bucketed hash table with tag match and depth/age replacement.
// ----------------------------------------------------------------------------
// channel  dir  transfer when          payload
// s_axis   in   tvalid & tready        cmd,hash,depth,value,eval,move,type,age
// m_axis   out  tvalid & tready        hit,stored,depth,value,eval,move,type
// apb      in   psel&penable&pwrite    table_enabled @0, bucket_count @4
//
// Save/load: the back end handles one item at a time, stepping through accept,
// memory read, decide/write and out (accept and out only while disabled), and
// waits in out while the output stalls. Clear: sweeps 2**BUCKET_BITS buckets,
// one per cycle, then answers; when disabled it answers without a sweep. After
// reset the same sweep runs before items start. The index stage and two-entry
// queue let input keep flowing while the back end stalls.
module hash_bucket_table_replace_unit #(
  parameter int WAYS        = hbtr_pkg::DEF_WAYS,
  parameter int BUCKET_BITS = hbtr_pkg::DEF_BUCKET_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd[1:0] key_hash[65:2] search_depth[73:66] score_value[89:74]
  // static_eval[105:90] best_move[121:106] bound_type[123:122] search_age[129:124]
  input  logic [hbtr_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit[0] stored[1] found_depth[9:2] found_value[25:10] found_eval[41:26]
  // found_move[57:42] found_type[59:58]
  output logic [hbtr_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbtr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hbtr_pkg::*;

  logic              table_enabled;
  logic [BCNT_W-1:0] bucket_count;
  logic              q_valid, q_ready;
  op_t               q_op;
  logic [BUCKET_BITS-1:0] q_bucket;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_enabled <= 1'b1;
      bucket_count  <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_ENABLE) table_enabled <= pwdata[0];
      if (paddr == REG_BCOUNT) bucket_count  <= pwdata[BCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ENABLE) prdata = {31'd0, table_enabled};
    else if (paddr == REG_BCOUNT) prdata = {19'd0, bucket_count};
  end

  hbtr_front #(.BUCKET_BITS(BUCKET_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .enabled(table_enabled), .bcount(bucket_count),
    .q_valid, .q_ready, .q_op, .q_bucket
  );

  hbtr_back #(.WAYS(WAYS), .BUCKET_BITS(BUCKET_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op, .q_bucket,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

  a_hit_stored: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit and stored together");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[59:2] == '0)
    else $error("miss carries data");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bucketed hash table: a golden table model
// predicts every response from each accepted command, responses are checked
// field by field in order, with random idles on both streams and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import hbtr_pkg::*;

  localparam int NB = 1 << DEF_BUCKET_BITS;
  localparam int NW = DEF_WAYS;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] hash;
    logic [7:0]  depth;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [1:0]  btype;
    logic [5:0]  age;
  } cmd_item_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  way_t        golden_tbl [NB][NW];
  logic        mdl_enabled;
  logic [12:0] mdl_bcount;
  res_t        expected_q [$];
  int          n_mismatch;
  logic        steady;
  int          hold_cycles;
  logic [63:0] key_pool [16];

  hash_bucket_table_replace_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // response ready: random idles, long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles   = hold_cycles - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = steady || ($urandom_range(99) >= 34);
      end
    end
  end

  // response checker
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit    = m_axis_tdata[0];
      got.stored = m_axis_tdata[1];
      got.depth  = m_axis_tdata[9:2];
      got.value  = m_axis_tdata[25:10];
      got.eval   = m_axis_tdata[41:26];
      got.move   = m_axis_tdata[57:42];
      got.btype  = m_axis_tdata[59:58];
      if (expected_q.size() == 0) begin
        n_mismatch = n_mismatch + 1;
        if (n_mismatch <= 10) $display("unexpected response %h", m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit || got.stored !== want.stored ||
            got.depth !== want.depth || got.value !== want.value ||
            got.eval !== want.eval || got.move !== want.move ||
            got.btype !== want.btype) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10)
            $display("mismatch: exp hit=%0d st=%0d d=%h v=%h e=%h m=%h t=%0d",
                     want.hit, want.stored, want.depth, want.value, want.eval,
                     want.move, want.btype,
                     " got hit=%0d st=%0d d=%h v=%h e=%h m=%h t=%0d",
                     got.hit, got.stored, got.depth, got.value, got.eval,
                     got.move, got.btype);
        end
      end
    end
  end

  function automatic logic [11:0] bucket_index(logic [63:0] h);
    logic [127:0] prod;
    int unsigned  n;
    n = mdl_bcount;
    if (n == 0) n = 1;
    if (n > NB) n = NB;
    prod = {64'd0, h} * n;
    return prod[75:64];
  endfunction

  function automatic res_t table_response(cmd_item_t it);
    res_t        r;
    logic [11:0] b;
    int          pick;
    int          cur_cur, pick_cur, shallower;
    logic        done;
    r = '0;
    if (!mdl_enabled) return r;
    b = bucket_index(it.hash);
    case (it.cmd)
      CMD_SAVE: begin
        pick = 0;
        done = 1'b0;
        for (int i = 0; i < NW; i++) begin
          if (!done) begin
            if (golden_tbl[b][i].tag == it.hash[15:0]) begin
              pick = i;
              done = 1'b1;
            end else begin
              cur_cur   = (golden_tbl[b][i].age_type[7:2] == it.age);
              pick_cur  = (golden_tbl[b][pick].age_type[7:2] == it.age);
              shallower = (golden_tbl[b][i].depth < golden_tbl[b][pick].depth);
              if (cur_cur - pick_cur - shallower < 0) pick = i;
            end
          end
        end
        if (!(it.depth == 0 && golden_tbl[b][pick].depth > 0 &&
              golden_tbl[b][pick].age_type[7:2] == it.age)) begin
          golden_tbl[b][pick].tag      = it.hash[15:0];
          golden_tbl[b][pick].depth    = it.depth;
          golden_tbl[b][pick].value    = it.value;
          golden_tbl[b][pick].eval     = it.eval;
          golden_tbl[b][pick].move     = it.move;
          golden_tbl[b][pick].age_type = {it.age, it.btype};
          r.stored = 1'b1;
        end
      end
      CMD_LOAD: begin
        done = 1'b0;
        for (int i = 0; i < NW; i++) begin
          if (!done && golden_tbl[b][i].tag == it.hash[15:0]) begin
            done    = 1'b1;
            r.hit   = 1'b1;
            r.depth = golden_tbl[b][i].depth;
            r.value = golden_tbl[b][i].value;
            r.eval  = golden_tbl[b][i].eval;
            r.move  = golden_tbl[b][i].move;
            r.btype = golden_tbl[b][i].age_type[1:0];
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NB; i++)
          for (int j = 0; j < NW; j++) golden_tbl[i][j] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(cmd_item_t it);
    while (!steady && $urandom_range(99) < 34) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, it.age, it.btype, it.move, it.eval, it.value,
                     it.depth, it.hash, it.cmd};
    do @(posedge clk); while (!s_axis_tready);
    expected_q = {expected_q, table_response(it)};
    @(negedge clk);
  endtask

  task automatic go_idle();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    go_idle();
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (addr == REG_ENABLE) mdl_enabled = data[0];
    else if (addr == REG_BCOUNT) mdl_bcount = data[12:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic cmd_item_t make_cmd(cmd_t c, logic [63:0] h, logic [7:0] d,
                                         logic [5:0] age);
    cmd_item_t it;
    it.cmd   = c;
    it.hash  = h;
    it.depth = d;
    it.value = 16'($urandom);
    it.eval  = 16'($urandom);
    it.move  = 16'($urandom);
    it.btype = 2'($urandom);
    it.age   = age;
    return it;
  endfunction

  task automatic test_directed();
    cmd_item_t it;
    send_cmd(make_cmd(CMD_LOAD, 64'd0, 8'd0, 6'd0));          // empty way, tag zero
    send_cmd(make_cmd(CMD_LOAD, 64'h1234, 8'd0, 6'd0));
    it = make_cmd(CMD_SAVE, '1, 8'hFF, 6'h3F);
    it.value = 16'h7FFF; it.eval = 16'h8000; it.move = 16'hFFFF; it.btype = 2'd3;
    send_cmd(it);
    send_cmd(make_cmd(CMD_LOAD, '1, 8'd0, 6'd0));
    it = make_cmd(CMD_SAVE, 64'hFFFF_FFFF_FFFF_0000, 8'd0, 6'd0);
    it.value = 16'h8000; it.eval = 16'h7FFF; it.move = 16'd0; it.btype = 2'd0;
    send_cmd(it);
    send_cmd(make_cmd(CMD_LOAD, 64'hFFFF_FFFF_FFFF_0000, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_SAVE, 64'h8000_0000_0000_0042, 8'd10, 6'd5));
    send_cmd(make_cmd(CMD_SAVE, 64'h8000_0000_0000_0042, 8'd0, 6'd5)); // shallow, skipped
    send_cmd(make_cmd(CMD_SAVE, 64'h8000_0000_0000_0042, 8'd0, 6'd6)); // old age, stored
    send_cmd(make_cmd(CMD_LOAD, 64'h8000_0000_0000_0042, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_NONE, '1, 8'hFF, 6'h3F));
    for (int i = 0; i < 6; i++)
      send_cmd(make_cmd(CMD_SAVE, {16'h4000, 32'd0, 16'(i + 1)}, 8'(i), 6'(i % 2)));
    send_cmd(make_cmd(CMD_LOAD, {16'h4000, 32'd0, 16'd1}, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_LOAD, {16'h4000, 32'd0, 16'd6}, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_CLEAR, 64'd0, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_LOAD, 64'h8000_0000_0000_0042, 8'd0, 6'd0));
    send_cmd(make_cmd(CMD_LOAD, '1, 8'd0, 6'd0));
  endtask

  function automatic cmd_item_t rand_cmd();
    cmd_item_t   it;
    int unsigned r;
    logic [63:0] h;
    r = $urandom_range(99);
    h = ($urandom_range(99) < 85) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
    it = make_cmd(r < 48 ? CMD_SAVE : r < 95 ? CMD_LOAD : r < 97 ? CMD_CLEAR : CMD_NONE,
                  h, ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
                  ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1)));
    return it;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
  endtask

  task automatic test_settings();
    logic [12:0] counts [7];
    counts = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd4097, 13'd3, 13'd0};
    counts[6] = 13'($urandom_range(1, 8191));
    for (int p = 0; p < 7; p++) begin
      apb_write(REG_BCOUNT, {19'd0, counts[p]});
      apb_write(REG_ENABLE, 32'd1);
      steady = (p == 2);
      test_random(60);
      steady = 1'b0;
    end
    apb_write(REG_ENABLE, 32'd0);
    test_random(20);
    send_cmd(make_cmd(CMD_CLEAR, 64'd0, 8'd0, 6'd0));
    apb_write(REG_ENABLE, 32'd1);
    test_random(20);
  endtask

  task automatic test_stall();
    apb_write(REG_BCOUNT, 32'd2);
    hold_cycles = 300;
    test_random(25);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    steady = 1'b0; hold_cycles = 0; n_mismatch = 0;
    mdl_enabled = 1'b1; mdl_bcount = 13'd4096;
    for (int i = 0; i < NB; i++)
      for (int j = 0; j < NW; j++) golden_tbl[i][j] = '0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0][15:0] = 16'd0;
    key_pool[1] = {~key_pool[2][63:16], key_pool[2][15:0]};
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_stall();
    test_settings();
    test_random(40);
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/hbtr_pkg.sv
rtl/hbtr_front.sv
rtl/hbtr_back.sv
rtl/hash_bucket_table_replace_unit.sv
test/tb_top.sv
